>>> hdl/small_risc_execute_unit_defines.svh
// assertion macros shared by the execute unit
`ifndef SMALL_RISC_EXECUTE_UNIT_DEFINES_SVH
`define SMALL_RISC_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SRE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("execute unit check failed");

// next-cycle implication, clocked on clk, off during rst
`define SRE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("execute unit check failed");

`endif

>>> hdl/sre_pkg.sv
`default_nettype none

package sre_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned REG_IDX_BITS = 5;

  localparam logic [WORD_BITS-1:0] PC_STEP = 32'd4;
  localparam int unsigned UPPER_SHIFT = 16;
  localparam logic [REG_IDX_BITS-1:0] CALL_ARG_REG = 5'd6;
  localparam logic [REG_IDX_BITS-1:0] CALL_DATA_REG = 5'd7;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_ADDI    = 4'd2,
    OP_SUBI    = 4'd3,
    OP_BEQ     = 4'd4,
    OP_BNE     = 4'd5,
    OP_BLT     = 4'd6,
    OP_BGE     = 4'd7,
    OP_STORE   = 4'd8,
    OP_LOAD    = 4'd9,
    OP_JMP     = 4'd10,
    OP_JMPR    = 4'd11,
    OP_CALL    = 4'd12,
    OP_AUIPC   = 4'd13,
    OP_REPLY   = 4'd14,
    OP_ILLEGAL = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_CALL  = 2'd3
  } req_kind_t;

  typedef struct packed {
    op_t                     op;
    logic [REG_IDX_BITS-1:0] dest_reg;
    logic [REG_IDX_BITS-1:0] src_a_reg;
    logic [REG_IDX_BITS-1:0] src_b_reg;
    logic signed [10:0]      branch_offset;
    logic signed [15:0]      word_immediate;
    logic [WORD_BITS-1:0]    reply_data;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]    next_pc;
    req_kind_t               request_kind;
    logic [WORD_BITS-1:0]    request_address;
    logic [WORD_BITS-1:0]    request_data;
    logic                    reg_write;
    logic [REG_IDX_BITS-1:0] written_reg;
    logic [WORD_BITS-1:0]    written_value;
    logic                    illegal_op;
  } result_t;

  typedef struct packed {
    logic                    en;
    logic [REG_IDX_BITS-1:0] idx;
    logic [WORD_BITS-1:0]    data;
  } rf_wr_t;

endpackage

`default_nettype wire

>>> hdl/sre_regfile.sv
`default_nettype none

module sre_regfile
  import sre_pkg::*;
#(
  parameter int unsigned REG_COUNT = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    rd_en,
  input  wire logic [REG_IDX_BITS-1:0] rd_addr_a,
  input  wire logic [REG_IDX_BITS-1:0] rd_addr_b,
  output logic      [WORD_BITS-1:0]    rd_data_a,
  output logic      [WORD_BITS-1:0]    rd_data_b,
  input  wire rf_wr_t                  wr
);

  localparam int unsigned IDX_W = $clog2(REG_COUNT);

  logic [WORD_BITS-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  logic [WORD_BITS-1:0] data_a;
  logic [WORD_BITS-1:0] data_b;
  logic                 ok_a;
  logic                 ok_b;

  logic in_range_a;
  logic in_range_b;
  logic byp_a;
  logic byp_b;

  assign in_range_a = 32'(rd_addr_a) < 32'(REG_COUNT);
  assign in_range_b = 32'(rd_addr_b) < 32'(REG_COUNT);
  // a write landing on the same edge wins over the stored word
  assign byp_a = wr.en && (wr.idx == rd_addr_a);
  assign byp_b = wr.en && (wr.idx == rd_addr_b);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      data_a <= byp_a ? wr.data : mem[rd_addr_a[IDX_W-1:0]];
      data_b <= byp_b ? wr.data : mem[rd_addr_b[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ok_a  <= 1'b0;
      ok_b  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.idx[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        ok_a <= in_range_a && (byp_a || valid[rd_addr_a[IDX_W-1:0]]);
        ok_b <= in_range_b && (byp_b || valid[rd_addr_b[IDX_W-1:0]]);
      end
    end
  end

  assign rd_data_a = ok_a ? data_a : '0;
  assign rd_data_b = ok_b ? data_b : '0;

endmodule

`default_nettype wire

>>> hdl/sre_exec.sv
`default_nettype none

module sre_exec
  import sre_pkg::*;
#(
  parameter int unsigned REG_COUNT = 32
) (
  input  wire item_t                   item,
  input  wire logic [WORD_BITS-1:0]    pc,
  input  wire logic [REG_IDX_BITS-1:0] pending,
  input  wire logic [WORD_BITS-1:0]    opnd_a,
  input  wire logic [WORD_BITS-1:0]    opnd_b,
  output result_t                      res,
  output logic [REG_IDX_BITS-1:0]      pending_next
);

  logic [WORD_BITS-1:0]    pc4;
  logic [WORD_BITS-1:0]    boff32;
  logic [WORD_BITS-1:0]    imm32;
  logic [WORD_BITS-1:0]    a_imm;
  logic                    wen_raw;
  logic                    wen;
  logic [REG_IDX_BITS-1:0] wreg;
  logic [WORD_BITS-1:0]    wval;

  always_comb begin
    pc4     = pc + PC_STEP;
    boff32  = WORD_BITS'(item.branch_offset);
    imm32   = WORD_BITS'(item.word_immediate);
    a_imm   = opnd_a + imm32;
    res     = '0;
    res.next_pc = pc4;
    wen_raw = 1'b0;
    wreg    = item.dest_reg;
    wval    = '0;
    pending_next = pending;

    unique case (item.op)
      OP_ADD: begin
        wen_raw = 1'b1;
        wval    = opnd_a + opnd_b;
      end
      OP_SUB: begin
        wen_raw = 1'b1;
        wval    = opnd_a - opnd_b;
      end
      OP_ADDI: begin
        wen_raw = 1'b1;
        wval    = a_imm;
      end
      OP_SUBI: begin
        wen_raw = 1'b1;
        wval    = opnd_a - imm32;
      end
      OP_BEQ: begin
        if (opnd_a == opnd_b) res.next_pc = pc + boff32;
      end
      OP_BNE: begin
        if (opnd_a != opnd_b) res.next_pc = pc + boff32;
      end
      OP_BLT: begin
        if ($signed(opnd_a) < $signed(opnd_b)) res.next_pc = pc + boff32;
      end
      OP_BGE: begin
        if ($signed(opnd_a) >= $signed(opnd_b)) res.next_pc = pc + boff32;
      end
      OP_STORE: begin
        // port b carries the store source register
        res.request_kind    = REQ_WRITE;
        res.request_address = a_imm;
        res.request_data    = opnd_b;
      end
      OP_LOAD: begin
        res.request_kind    = REQ_READ;
        res.request_address = a_imm;
        pending_next        = item.dest_reg;
      end
      OP_JMP: begin
        wen_raw     = 1'b1;
        wval        = pc4;
        res.next_pc = pc + imm32;
      end
      OP_JMPR: begin
        wen_raw     = 1'b1;
        wval        = pc4;
        res.next_pc = a_imm;
      end
      OP_CALL: begin
        // ports read r6 and r7 for a call
        res.request_kind    = REQ_CALL;
        res.request_address = opnd_a;
        res.request_data    = opnd_b;
        pending_next        = CALL_ARG_REG;
      end
      OP_AUIPC: begin
        wen_raw = 1'b1;
        wval    = pc + (imm32 << UPPER_SHIFT);
      end
      OP_REPLY: begin
        res.next_pc = pc;
        wen_raw     = 1'b1;
        wreg        = pending;
        wval        = item.reply_data;
      end
      OP_ILLEGAL: begin
        res.next_pc    = pc;
        res.illegal_op = 1'b1;
      end
    endcase

    wen = wen_raw && (wreg != '0) && (32'(wreg) < 32'(REG_COUNT));
    res.reg_write     = wen;
    res.written_reg   = wen ? wreg : '0;
    res.written_value = wen ? wval : '0;
  end

endmodule

`default_nettype wire

>>> hdl/small_risc_execute_unit.sv
// small risc execute unit
// s_* stream: one decoded instruction per transfer, op in s_tuser, register
//   numbers, offsets and reply data packed in s_tdata
// m_* stream: one result per instruction (next pc, memory or service request,
//   register write report, illegal flag)
// a result reaches m_tvalid after its input transfer: the transfer edge
//   latches the register file read, and execute is registered into the
//   output register once that register is free or being drained
// throughput: one instruction per cycle while m_tready keeps up; the register
//   file is a memory with two registered read ports, and a write at the end of
//   execute is bypassed into the read of the following instruction on the same edge
// loads and calls issue a request and remember the destination; a later
//   reply instruction writes its data there and leaves the pc unchanged
// reset: pc, pending destination and all registers read zero at once (per
//   entry valid bits), no clearing pass; s_tready stays low while rst is high
//   and input is taken right after reset
// stall: while m_tready is low the result holds, one more instruction may
//   wait in execute, then s_tready drops
`default_nettype none

`include "small_risc_execute_unit_defines.svh"

module small_risc_execute_unit
  import sre_pkg::*;
#(
  parameter int unsigned REG_COUNT = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // dest_reg[4:0], src_a_reg[9:5], src_b_reg[14:10], branch_offset[25:15],
  // word_immediate[41:26], reply_data[73:42], zero fill [79:74]
  input  wire logic [79:0]  s_tdata,
  // op[3:0]
  input  wire logic [3:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // next_pc[31:0], request_address[63:32], request_data[95:64],
  // written_reg[100:96], written_value[132:101], zero fill [135:133]
  output logic [135:0]      m_tdata,
  // request_kind[1:0], reg_write[2], illegal_op[3]
  output logic [3:0]        m_tuser
);

  // input unpack
  item_t in_item;
  assign in_item.op             = op_t'(s_tuser);
  assign in_item.dest_reg       = s_tdata[4:0];
  assign in_item.src_a_reg      = s_tdata[9:5];
  assign in_item.src_b_reg      = s_tdata[14:10];
  assign in_item.branch_offset  = s_tdata[25:15];
  assign in_item.word_immediate = s_tdata[41:26];
  assign in_item.reply_data     = s_tdata[73:42];

  logic s_xfer;
  logic ex_valid;
  logic ex_fire;
  item_t ex_item;

  logic [WORD_BITS-1:0]    pc;
  logic [REG_IDX_BITS-1:0] pending;

  logic [REG_IDX_BITS-1:0] rd_addr_a;
  logic [REG_IDX_BITS-1:0] rd_addr_b;
  logic [WORD_BITS-1:0]    opnd_a;
  logic [WORD_BITS-1:0]    opnd_b;

  result_t                 ex_res;
  logic [REG_IDX_BITS-1:0] pending_next;
  rf_wr_t                  rf_wr;
  result_t                 res_q;

  // execute advances when the output register is free or being drained
  assign ex_fire  = ex_valid && (!m_tvalid || m_tready);
  // no transfer is taken while reset is held
  assign s_tready = !rst && (!ex_valid || ex_fire);
  assign s_xfer   = s_tvalid && s_tready;

  // read port steering: calls read r6/r7, store reads its data source on b
  always_comb begin
    rd_addr_a = in_item.src_a_reg;
    rd_addr_b = in_item.src_b_reg;
    if (in_item.op == OP_CALL) begin
      rd_addr_a = CALL_ARG_REG;
      rd_addr_b = CALL_DATA_REG;
    end else if (in_item.op == OP_STORE) begin
      rd_addr_b = in_item.dest_reg;
    end
  end

  sre_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (s_xfer),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (opnd_a),
    .rd_data_b (opnd_b),
    .wr        (rf_wr)
  );

  sre_exec #(
    .REG_COUNT(REG_COUNT)
  ) u_exec (
    .item         (ex_item),
    .pc           (pc),
    .pending      (pending),
    .opnd_a       (opnd_a),
    .opnd_b       (opnd_b),
    .res          (ex_res),
    .pending_next (pending_next)
  );

  // write back on the edge the instruction leaves execute
  assign rf_wr.en   = ex_fire && ex_res.reg_write;
  assign rf_wr.idx  = ex_res.written_reg;
  assign rf_wr.data = ex_res.written_value;

  // instruction register beside the registered read data
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      ex_item <= in_item;
    end
    if (ex_fire) begin
      res_q <= ex_res;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      m_tvalid <= 1'b0;
      pc       <= '0;
      pending  <= '0;
    end else begin
      if (s_xfer) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        m_tvalid <= 1'b1;
        pc       <= ex_res.next_pc;
        pending  <= pending_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output pack
  assign m_tdata = {3'b000, res_q.written_value, res_q.written_reg,
                    res_q.request_data, res_q.request_address, res_q.next_pc};
  assign m_tuser = {res_q.illegal_op, res_q.reg_write, res_q.request_kind};

  `SRE_ASSERT_NOW(a_no_zero_write, m_tvalid && res_q.reg_write, res_q.written_reg != '0)
  `SRE_ASSERT_NOW(a_pc_tracks_result, m_tvalid, pc == res_q.next_pc)
  `SRE_ASSERT_NEXT(a_ex_held, ex_valid && !ex_fire, ex_valid && $stable(ex_item))
  `SRE_ASSERT_NOW(a_room_when_ready, s_tready && ex_valid, !m_tvalid || m_tready)

endmodule

`default_nettype wire

>>> tb/tb_small_risc_execute_unit.sv
module tb_small_risc_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sre_pkg::*;

  // run sizing
  localparam int unsigned RANDOM_PER_PHASE = 425;
  localparam int unsigned PHASES = 4;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  // one row of the directed table; fixed rows carry a hand-written result
  typedef struct {
    item_t   instr;
    bit      fixed;
    result_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [3:0]   m_tuser;

  // architectural copy kept by the predictor
  logic [WORD_BITS-1:0]    arch_regs [32];
  logic [WORD_BITS-1:0]    arch_pc;
  logic [REG_IDX_BITS-1:0] arch_pending;

  // results still owed by the block, oldest first
  result_t retire_q[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned random_sent = 0;
  bit          awaiting_reply = 1'b0;
  dir_row_t    dir_table[$];

  small_risc_execute_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // predictor: executes one instruction on the architectural copy
  function automatic result_t execute_instr(item_t it);
    result_t                 r;
    logic [WORD_BITS-1:0]    a, b, imm, boff, wv;
    logic [REG_IDX_BITS-1:0] wr;
    logic                    we;
    r = '0;
    // register zero is never written, so it always reads zero
    a = arch_regs[it.src_a_reg];
    b = arch_regs[it.src_b_reg];
    imm = {{16{it.word_immediate[15]}}, it.word_immediate};
    boff = {{21{it.branch_offset[10]}}, it.branch_offset};
    r.next_pc = arch_pc + PC_STEP;
    r.request_kind = REQ_NONE;
    we = 1'b0;
    wr = it.dest_reg;
    wv = '0;
    case (it.op)
      OP_ADD: begin
        we = 1'b1;
        wv = a + b;
      end
      OP_SUB: begin
        we = 1'b1;
        wv = a - b;
      end
      OP_ADDI: begin
        we = 1'b1;
        wv = a + imm;
      end
      OP_SUBI: begin
        we = 1'b1;
        wv = a - imm;
      end
      OP_BEQ: if (a == b) r.next_pc = arch_pc + boff;
      OP_BNE: if (a != b) r.next_pc = arch_pc + boff;
      OP_BLT: if ($signed(a) < $signed(b)) r.next_pc = arch_pc + boff;
      OP_BGE: if ($signed(a) >= $signed(b)) r.next_pc = arch_pc + boff;
      OP_STORE: begin
        r.request_kind = REQ_WRITE;
        r.request_address = a + imm;
        r.request_data = arch_regs[it.dest_reg];
      end
      OP_LOAD: begin
        r.request_kind = REQ_READ;
        r.request_address = a + imm;
        arch_pending = it.dest_reg;
      end
      OP_JMP: begin
        we = 1'b1;
        wv = arch_pc + PC_STEP;
        r.next_pc = arch_pc + imm;
      end
      OP_JMPR: begin
        // base is read before the link lands
        we = 1'b1;
        wv = arch_pc + PC_STEP;
        r.next_pc = a + imm;
      end
      OP_CALL: begin
        r.request_kind = REQ_CALL;
        r.request_address = arch_regs[CALL_ARG_REG];
        r.request_data = arch_regs[CALL_DATA_REG];
        arch_pending = CALL_ARG_REG;
      end
      OP_AUIPC: begin
        we = 1'b1;
        wv = arch_pc + (imm << UPPER_SHIFT);
      end
      OP_REPLY: begin
        // pending destination is kept, a second reply writes again
        r.next_pc = arch_pc;
        we = 1'b1;
        wr = arch_pending;
        wv = it.reply_data;
      end
      default: begin
        r.next_pc = arch_pc;
        r.illegal_op = 1'b1;
      end
    endcase
    if (we && wr != '0) begin
      arch_regs[wr] = wv;
      r.reg_write = 1'b1;
      r.written_reg = wr;
      r.written_value = wv;
    end
    arch_pc = r.next_pc;
    return r;
  endfunction

  function automatic item_t ins(op_t op, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                                logic signed [10:0] boff, logic signed [15:0] imm,
                                logic [31:0] reply);
    item_t it;
    it.op = op;
    it.dest_reg = rd;
    it.src_a_reg = ra;
    it.src_b_reg = rb;
    it.branch_offset = boff;
    it.word_immediate = imm;
    it.reply_data = reply;
    return it;
  endfunction

  function automatic result_t res(logic [31:0] npc, req_kind_t kind, logic [31:0] addr,
                                  logic [31:0] data, logic we, logic [4:0] wr,
                                  logic [31:0] wv, logic ill);
    result_t r;
    r.next_pc = npc;
    r.request_kind = kind;
    r.request_address = addr;
    r.request_data = data;
    r.reg_write = we;
    r.written_reg = wr;
    r.written_value = wv;
    r.illegal_op = ill;
    return r;
  endfunction

  // half the picks land in the low registers so values get reused
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) != 0) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  // random instruction; loads and calls are mostly followed by their reply
  function automatic item_t rand_instr();
    item_t       it;
    int unsigned pick;
    it.dest_reg = pick_reg();
    it.src_a_reg = pick_reg();
    it.src_b_reg = pick_reg();
    it.branch_offset = 11'($urandom);
    case ($urandom_range(0, 15))
      0: it.word_immediate = 16'h8000;
      1: it.word_immediate = 16'h7fff;
      2: it.word_immediate = 16'hffff;
      3: it.word_immediate = 16'h0000;
      default: it.word_immediate = 16'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0: it.reply_data = 32'h0000_0000;
      1: it.reply_data = 32'hffff_ffff;
      2: it.reply_data = 32'h8000_0000;
      default: it.reply_data = $urandom;
    endcase
    pick = $urandom_range(0, 19);
    if (awaiting_reply && $urandom_range(0, 3) != 0) it.op = OP_REPLY;
    else if (pick >= 16) it.op = pick[0] ? OP_LOAD : OP_CALL;
    else it.op = op_t'(pick[3:0]);
    // equal operands so compare branches see the boundary
    if (it.op >= OP_BEQ && it.op <= OP_BGE && $urandom_range(0, 2) == 0)
      it.src_b_reg = it.src_a_reg;
    awaiting_reply = (it.op == OP_LOAD || it.op == OP_CALL);
    return it;
  endfunction

  // offer one instruction, wait for its transfer, then book its result
  task automatic send_instr(input item_t it, input bit fixed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, it.reply_data, it.word_immediate, it.branch_offset,
                it.src_b_reg, it.src_a_reg, it.dest_reg};
    s_tuser <= it.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = execute_instr(it);
    retire_q.push_back(fixed ? want : predicted);
  endtask

  // sender goes quiet until every booked result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus long hold-offs counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (holds_asked != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker; outputs sampled as they stood at the edge
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got.next_pc = m_tdata[31:0];
      got.request_address = m_tdata[63:32];
      got.request_data = m_tdata[95:64];
      got.written_reg = m_tdata[100:96];
      got.written_value = m_tdata[132:101];
      got.request_kind = req_kind_t'(m_tuser[1:0]);
      got.reg_write = m_tuser[2];
      got.illegal_op = m_tuser[3];
      if (retire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: result transfer with nothing outstanding, pc=%h",
                   cycles, got.next_pc);
      end else begin
        want = retire_q.pop_front();
        if (got.next_pc !== want.next_pc || got.request_kind !== want.request_kind ||
            got.request_address !== want.request_address ||
            got.request_data !== want.request_data || got.reg_write !== want.reg_write ||
            got.written_reg !== want.written_reg ||
            got.written_value !== want.written_value ||
            got.illegal_op !== want.illegal_op) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("cycle %0d want: pc=%h kind=%0d addr=%h data=%h we=%b reg=%0d val=%h ill=%b",
                     cycles, want.next_pc, want.request_kind, want.request_address,
                     want.request_data, want.reg_write, want.written_reg,
                     want.written_value, want.illegal_op);
            $display("cycle %0d got:  pc=%h kind=%0d addr=%h data=%h we=%b reg=%0d val=%h ill=%b",
                     cycles, got.next_pc, got.request_kind, got.request_address,
                     got.request_data, got.reg_write, got.written_reg,
                     got.written_value, got.illegal_op);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, retire_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = '0;
    arch_pending = '0;

    // pc starts at zero, so the first rows can be written out by hand
    dir_table.push_back('{ins(OP_REPLY, 3, 0, 0, 0, 0, 32'hffff_ffff), 1'b1,
                          res(0, REQ_NONE, 0, 0, 0, 0, 0, 0)});
    dir_table.push_back('{ins(OP_ILLEGAL, 31, 31, 31, -1, -1, 32'hffff_ffff), 1'b1,
                          res(0, REQ_NONE, 0, 0, 0, 0, 0, 1)});
    dir_table.push_back('{ins(OP_ADD, 1, 0, 0, 0, 0, 0), 1'b1,
                          res(4, REQ_NONE, 0, 0, 1, 1, 0, 0)});
    dir_table.push_back('{ins(OP_ADDI, 2, 0, 0, 0, 32767, 0), 1'b1,
                          res(8, REQ_NONE, 0, 0, 1, 2, 32'h0000_7fff, 0)});
    dir_table.push_back('{ins(OP_ADDI, 3, 0, 0, 0, -32768, 0), 1'b1,
                          res(12, REQ_NONE, 0, 0, 1, 3, 32'hffff_8000, 0)});
    dir_table.push_back('{ins(OP_ADDI, 0, 0, 0, 0, 5, 0), 1'b1,
                          res(16, REQ_NONE, 0, 0, 0, 0, 0, 0)});
    // from here on the predictor supplies the result
    dir_table.push_back('{ins(OP_SUB, 4, 3, 2, 0, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_SUBI, 5, 3, 0, 0, -32768, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_BEQ, 0, 0, 0, -1024, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_BNE, 0, 2, 3, 1023, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_BLT, 0, 3, 2, 8, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_BGE, 0, 3, 2, 8, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_BGE, 0, 2, 2, -4, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_AUIPC, 31, 0, 0, 0, -32768, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_AUIPC, 8, 0, 0, 0, 32767, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_STORE, 31, 2, 0, 0, -1, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_LOAD, 9, 3, 0, 0, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_REPLY, 0, 0, 0, 0, 0, 32'hffff_ffff), 1'b0, '0});
    // a second reply hits the same pending register
    dir_table.push_back('{ins(OP_REPLY, 0, 0, 0, 0, 0, 32'h0), 1'b0, '0});
    dir_table.push_back('{ins(OP_ADDI, 6, 2, 0, 0, 1, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_SUBI, 7, 0, 0, 0, 1, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_CALL, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_REPLY, 0, 0, 0, 0, 0, 32'hdead_beef), 1'b0, '0});
    // load into register zero, so its reply is dropped
    dir_table.push_back('{ins(OP_LOAD, 0, 4, 0, 0, 32767, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_REPLY, 0, 0, 0, 0, 0, 32'h1234_5678), 1'b0, '0});
    dir_table.push_back('{ins(OP_JMP, 10, 0, 0, 0, -32768, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_JMPR, 11, 11, 0, 0, 32767, 0), 1'b0, '0});
    dir_table.push_back('{ins(OP_JMPR, 11, 11, 0, 0, 0, 0), 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, back to back
    foreach (dir_table[i]) send_instr(dir_table[i].instr, dir_table[i].fixed, dir_table[i].want);
    drain();

    // random part: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long output hold-off while instructions keep coming, input backs up
        if (n == 150 && (ph == 0 || ph == 3)) holds_asked++;
        send_instr(rand_instr(), 1'b0, '0);
        random_sent++;
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d directed and %0d random instructions in %0d cycles",
             dir_table.size(), random_sent, cycles);
    $display("checked %0d results over four traffic mixes with %0d long output hold-offs",
             results_seen, holds_served);
    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
